>>> rtl/bencode_integer_parser_defines.svh
// assertion macros for the bencode integer parser
// used by bencode_integer_parser.sv; expects clk and arst_n in scope
`ifndef BENCODE_INTEGER_PARSER_DEFINES_SVH
`define BENCODE_INTEGER_PARSER_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define BIP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked only out of reset
`define BIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bip_pkg.sv
// shared types, character codes and status codes of the bencode integer parser
// no dependencies
`default_nettype none

package bip_pkg;

	localparam int unsigned MAX_BODY_BYTES_DEF = 19;
	// body counter width, covers the default body length limit (limits up to 31)
	localparam int unsigned CNT_W = 5;
	localparam int unsigned VAL_W = 64;

	localparam logic [7:0] CH_START = 8'h69;
	localparam logic [7:0] CH_END   = 8'h65;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_INT   = 3'd1,
		ST_EOS       = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_NO_DIGITS = 3'd4,
		ST_OVERFLOW  = 3'd5
	} status_t;

	typedef struct packed {
		logic             in_token;
		logic [CNT_W-1:0] body_count;
		logic [VAL_W-1:0] magnitude;
		logic             negative;
		logic             scanning;
		logic             digit_seen;
		logic             overflowed;
	} tok_state_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] value;
		status_t          status;
	} tok_result_t;

	function automatic tok_state_t clear_body(input logic in_tok);
		tok_state_t s;
		s.in_token   = in_tok;
		s.body_count = '0;
		s.magnitude  = '0;
		s.negative   = 1'b0;
		s.scanning   = 1'b1;
		s.digit_seen = 1'b0;
		s.overflowed = 1'b0;
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/bip_step.sv
// one-word update of the token state and the result it causes
// depends on bip_pkg
`default_nettype none

module bip_step #(
	parameter int unsigned MAX_BODY_BYTES = bip_pkg::MAX_BODY_BYTES_DEF
) (
	input  bip_pkg::tok_state_t  cur,
	input  logic [7:0]           byte_in,
	input  logic                 end_of_stream,
	output bip_pkg::tok_state_t  nxt,
	output bip_pkg::tok_result_t res
);
	import bip_pkg::*;

	logic [VAL_W-1:0] prod;

	// magnitude*10 + digit as two shifts and two adds
	assign prod = {cur.magnitude[VAL_W-4:0], 3'b000} + {cur.magnitude[VAL_W-2:0], 1'b0}
		+ VAL_W'(byte_in[3:0]);

	always_comb begin
		nxt        = cur;
		res.valid  = 1'b0;
		res.value  = '0;
		res.status = ST_OK;
		if (!cur.in_token) begin
			if (end_of_stream) begin
				res.valid  = 1'b1;
				res.status = ST_EOS;
			end else if (byte_in == CH_START) begin
				nxt = clear_body(1'b1);
			end else begin
				res.valid  = 1'b1;
				res.status = ST_NOT_INT;
			end
		end else if (end_of_stream) begin
			nxt        = clear_body(1'b0);
			res.valid  = 1'b1;
			res.status = ST_EOS;
		end else if (byte_in == CH_END) begin
			nxt       = clear_body(1'b0);
			res.valid = 1'b1;
			if (cur.overflowed) begin
				res.status = ST_OVERFLOW;
			end else if (!cur.digit_seen) begin
				res.status = ST_NO_DIGITS;
			end else begin
				res.status = ST_OK;
				res.value  = cur.negative ? (VAL_W'(0) - cur.magnitude) : cur.magnitude;
			end
		end else if (cur.body_count >= CNT_W'(MAX_BODY_BYTES)) begin
			nxt        = clear_body(1'b0);
			res.valid  = 1'b1;
			res.status = ST_TOO_LONG;
		end else begin
			if (cur.body_count == '0 && byte_in == CH_MINUS) begin
				nxt.negative = 1'b1;
			end else if (cur.scanning) begin
				if (byte_in inside {[CH_ZERO:CH_NINE]}) begin
					nxt.magnitude  = prod;
					nxt.digit_seen = 1'b1;
					if (prod[VAL_W-1]) begin
						nxt.overflowed = 1'b1;
						nxt.scanning   = 1'b0;
					end
				end else begin
					nxt.scanning = 1'b0;
				end
			end
			nxt.body_count = cur.body_count + CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> rtl/bencode_integer_parser.sv
// Bencode integer parser: takes one stream byte per word (or an end-of-stream
// marker) and, for each token "i[-]digits e", a stray byte, an over-long
// body or an end of stream, delivers one word with a signed 64-bit value and a
// status (0 ok, 1 not an integer token, 2 stream ended, 3 too long, 4 no digits,
// 5 overflow). One byte is accepted every cycle unless input is held; a byte
// passes the input register, its result the output register. The rate is set
// by the token state register, which takes the x10-plus-digit add and the flag
// updates together. Input is held only when a result waits in the output
// register and the byte in the input register would produce another one.
// depends on bip_pkg, bip_step and bencode_integer_parser_defines.svh
`default_nettype none
`include "bencode_integer_parser_defines.svh"

module bencode_integer_parser #(
	parameter int unsigned MAX_BODY_BYTES = bip_pkg::MAX_BODY_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         byte_in,
	input  logic               end_of_stream,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] value,
	output logic [2:0]         status
);
	import bip_pkg::*;

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	tok_state_t  state_q;
	tok_state_t  state_nxt;
	tok_result_t res;
	logic        fire;
	logic        out_valid_q;
	logic [VAL_W-1:0] value_q;
	status_t     status_q;

	bip_step #(
		.MAX_BODY_BYTES(MAX_BODY_BYTES)
	) u_step (
		.cur          (state_q),
		.byte_in      (byte_s1),
		.end_of_stream(eos_s1),
		.nxt          (state_nxt),
		.res          (res)
	);

	// the registered word moves on unless its result has nowhere to go
	assign fire     = vld_s1 && (!res.valid || !out_valid_q || out_ready);
	assign in_ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			eos_s1  <= end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clear_body(1'b0);
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			value_q  <= res.value;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = $signed(value_q);
	assign status    = status_q;

	`BIP_ASSERT_NOW(a_value_zero_unless_ok, out_valid_q && status_q != ST_OK, value_q == '0, "nonzero value with error status")
	`BIP_ASSERT_NOW(a_idle_body_clear, !state_q.in_token, state_q.body_count == '0 && state_q.magnitude == '0 && !state_q.overflowed, "body state not cleared outside a token")
	`BIP_ASSERT_NOW(a_count_bound, 1'b1, state_q.body_count <= CNT_W'(MAX_BODY_BYTES), "body count past limit")
	`BIP_ASSERT_NEXT(a_no_lost_result, out_valid_q && !out_ready, out_valid_q, "pending result dropped")

endmodule

`default_nettype wire
